// ===== rtl/core/parallax_scroll_layers_unit_assert.svh =====
//----------------------------------------------------------------------------
// Parallax scroll layers: assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
//----------------------------------------------------------------------------
`ifndef PARALLAX_SCROLL_LAYERS_UNIT_ASSERT_SVH
`define PARALLAX_SCROLL_LAYERS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define PSL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// consequent in the cycle after the antecedent
`define PSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define PSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/psl_pkg.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers: shared package
// Field widths, command codes, register map and inter-module structs.
//----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

  // beat field widths
  localparam int MODE_W = 2;
  localparam int CAM_W  = 16;
  localparam int SEL_W  = 2;
  localparam int OFF_W  = 12;
  localparam int MASK_W = 4;

  // layer state
  localparam int MAX_LAYERS = 4;
  localparam int ACC_W      = 25;
  localparam int TILE_SHIFT = 4;   // 16 pixels per tile

  // defaults for the top level parameters
  localparam int PSL_LAYER_COUNT   = 4;
  localparam int PSL_FRACTION_BITS = 4;

  // configuration port
  localparam int CFG_W     = 8;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_TILES0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RATIO0 = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_ACT  = 2'd1,
    MODE_CLR  = 2'd2
  } psl_mode_t;

  typedef struct packed {
    logic [MAX_LAYERS-1:0][CFG_W-1:0] tiles;
    logic [MAX_LAYERS-1:0][CFG_W-1:0] ratio;
  } psl_cfg_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CFG_W-1:0] rem;
  } psl_mod_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/psl_in_if.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers: command channel
// Valid/ready channel carrying one command beat.
//----------------------------------------------------------------------------
`default_nettype none

interface psl_in_if;
  import psl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [CAM_W-1:0] camera_pos;
  logic [SEL_W-1:0]        layer_sel;

  modport source (output valid, output mode, output camera_pos, output layer_sel,
                  input ready);
  modport sink   (input valid, input mode, input camera_pos, input layer_sel,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psl_out_if.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers: result channel
// Valid/ready channel carrying the layer offsets and active mask.
//----------------------------------------------------------------------------
`default_nettype none

interface psl_out_if;
  import psl_pkg::*;

  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  offset_layer0;
  logic [OFF_W-1:0]  offset_layer1;
  logic [OFF_W-1:0]  offset_layer2;
  logic [OFF_W-1:0]  offset_layer3;
  logic [MASK_W-1:0] active_mask;

  modport source (output valid, output offset_layer0, output offset_layer1,
                  output offset_layer2, output offset_layer3, output active_mask,
                  input ready);
  modport sink   (input valid, input offset_layer0, input offset_layer1,
                  input offset_layer2, input offset_layer3, input active_mask,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psl_cfg_regs.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers: configuration registers
// APB-style register file for layer widths and parallax ratios.
//----------------------------------------------------------------------------
`default_nettype none

module psl_cfg_regs import psl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output psl_cfg_t                cfg
);

  logic [MAX_LAYERS-1:0][CFG_W-1:0] tiles_r;
  logic [MAX_LAYERS-1:0][CFG_W-1:0] ratio_r;
  logic [REG_IDX_W-1:0]             reg_idx;
  logic [1:0]                       slot;
  logic [CFG_W-1:0]                 rd_val;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign slot    = reg_idx[1:0];
  assign pready  = 1'b1;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
        tiles_r[i] <= CFG_W'(1);
        ratio_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      if (reg_idx < REG_RATIO0) begin
        tiles_r[slot] <= pwdata[CFG_W-1:0];
      end else begin
        ratio_r[slot] <= pwdata[CFG_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (reg_idx < REG_RATIO0) begin
      rd_val = tiles_r[slot];
    end else begin
      rd_val = ratio_r[slot];
    end
    prdata = {{(PDATA_W-CFG_W){1'b0}}, rd_val};
  end

  assign cfg.tiles = tiles_r;
  assign cfg.ratio = ratio_r;

endmodule

`default_nettype wire

// ===== rtl/core/psl_mod_unit.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers: remainder unit
// Bit-serial floored remainder of a signed value by the tile count.
//----------------------------------------------------------------------------
`default_nettype none

module psl_mod_unit import psl_pkg::*; #(
  parameter int Q_W = ACC_W - PSL_FRACTION_BITS - 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic signed [Q_W-1:0] value,
  input  wire logic [CFG_W-1:0]      tiles,
  output psl_mod_rsp_t               rsp
);

  localparam int CNT_W = $clog2(Q_W);

  logic [Q_W-1:0]   mag_r;
  logic [CFG_W-1:0] rem_r;
  logic [CFG_W-1:0] tiles_r;
  logic [CFG_W-1:0] res_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;

  logic [CFG_W:0]   step;
  logic [CFG_W:0]   step_sub;
  logic [CFG_W-1:0] rem_step;
  logic [CFG_W-1:0] rem_fix;

  // one quotient bit per cycle; floor fix-up for negative dividends
  always_comb begin
    step     = {rem_r, mag_r[Q_W-1]};
    step_sub = step - {1'b0, tiles_r};
    rem_step = (step >= {1'b0, tiles_r}) ? step_sub[CFG_W-1:0] : step[CFG_W-1:0];
    rem_fix  = (neg_r && rem_step != '0) ? (tiles_r - rem_step) : rem_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= value[Q_W-1];
        mag_r  <= value[Q_W-1] ? (~value + 1'b1) : value;
        rem_r  <= '0;
        tiles_r <= tiles;
        cnt_r  <= CNT_W'(Q_W - 1);
      end else if (busy_r) begin
        rem_r <= rem_step;
        mag_r <= {mag_r[Q_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= rem_fix;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/parallax_scroll_layers_unit.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers
// Camera-driven scroll accumulators and wrapped pixel offsets per layer.
//
//   channel  dir  handshake                 beat contents
//   in_beat  in   valid/ready               mode, camera_pos, layer_sel
//   out_beat out  valid/ready               offset_layer0..3, active_mask
//   cfg      in   psel/penable/pwrite/pready widths and ratios, 8 regs
//
// Clear and idle-camera ticks go straight to the result state; activate runs
// multiply, accumulate and remainder for one layer; a tick visits the layers
// in order, where active ones multiply, accumulate and take the pixel change,
// and moved ones of nonzero width use the remainder unit (one bit a cycle).
// The multiplier is shared by all layers. Synchronous reset leaves all layers
// inactive; a result held by a stalled sink does not block the next command.
//----------------------------------------------------------------------------
`default_nettype none

module parallax_scroll_layers_unit import psl_pkg::*; #(
  parameter int LAYER_COUNT   = PSL_LAYER_COUNT,
  parameter int FRACTION_BITS = PSL_FRACTION_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  psl_in_if.sink                  in_beat,
  psl_out_if.source               out_beat,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

`include "parallax_scroll_layers_unit_assert.svh"

  localparam int LIDX_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int PIX_W  = ACC_W - FRACTION_BITS;
  localparam int DIFF_W = PIX_W + 1;
  localparam int V_W    = PIX_W + 2;
  localparam int Q_W    = V_W - TILE_SHIFT;
  localparam int MUL_W  = CAM_W + CFG_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_T_MUL, S_T_ACC, S_T_DIF, S_T_OFF, S_A_MUL, S_A_ACC, S_MODW, S_FIN
  } state_t;

  psl_cfg_t     cfg;
  psl_mod_rsp_t mod_rsp;

  state_t                  state_r;
  logic [LIDX_W-1:0]       idx_r;
  logic                    act_r;
  logic [CAM_W-1:0]        cam_r;
  logic [ACC_W-1:0]        acc_r [LAYER_COUNT];
  logic [OFF_W-1:0]        po_r  [LAYER_COUNT];
  logic [LAYER_COUNT-1:0]  active_r;
  logic [CAM_W:0]          delta_r;
  logic [ACC_W-1:0]        prod_r;
  logic [PIX_W-1:0]        pix_before_r;
  logic [DIFF_W-1:0]       diff_r;
  logic [TILE_SHIFT-1:0]   lo_r;
  logic                    out_valid_r;
  logic [OFF_W-1:0]        out_po_r [MAX_LAYERS];
  logic [MASK_W-1:0]       out_mask_r;

  logic                    in_fire;
  logic                    sel_ok;
  logic [LIDX_W-1:0]       sel_idx;
  logic [CAM_W:0]          delta_in;
  logic [ACC_W-1:0]        acc_cur;
  logic [OFF_W-1:0]        po_cur;
  logic [CFG_W-1:0]        tiles_cur;
  logic [CFG_W-1:0]        ratio_cur;
  logic signed [CAM_W:0]   mul_a;
  logic signed [CFG_W:0]   mul_b;
  logic signed [MUL_W-1:0] mul_full;
  logic [ACC_W-1:0]        acc_sum;
  logic [PIX_W-1:0]        pix_now;
  logic [PIX_W-1:0]        pix_prod;
  logic [DIFF_W-1:0]       diff;
  logic [V_W-1:0]          v_tick;
  logic [V_W-1:0]          v_act;
  logic [V_W-1:0]          v_mod;
  logic                    mod_start;
  logic                    last_layer;
  logic                    out_load;
  logic [OFF_W-1:0]        po_view [MAX_LAYERS];
  logic [MASK_W-1:0]       mask_view;

  psl_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  psl_mod_unit #(.Q_W(Q_W)) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .value(v_mod[V_W-1:TILE_SHIFT]),
    .tiles(tiles_cur),
    .rsp  (mod_rsp)
  );

  // command decode
  assign in_beat.ready = (state_r == S_IDLE);
  assign in_fire       = in_beat.valid && in_beat.ready;
  assign sel_ok        = {1'b0, in_beat.layer_sel} < (SEL_W + 1)'(LAYER_COUNT);
  assign sel_idx       = in_beat.layer_sel[LIDX_W-1:0];
  assign delta_in      = {in_beat.camera_pos[CAM_W-1], in_beat.camera_pos} -
                         {cam_r[CAM_W-1], cam_r};

  // per-layer datapath, shared across layers
  always_comb begin
    acc_cur   = acc_r[idx_r];
    po_cur    = po_r[idx_r];
    tiles_cur = cfg.tiles[idx_r];
    ratio_cur = cfg.ratio[idx_r];
    mul_a     = (state_r == S_A_MUL) ? {cam_r[CAM_W-1], cam_r} : delta_r;
    mul_b     = {1'b0, ratio_cur};
    mul_full  = mul_a * mul_b;
    acc_sum   = acc_cur + prod_r;
    pix_now   = acc_cur[ACC_W-1:FRACTION_BITS];
    pix_prod  = prod_r[ACC_W-1:FRACTION_BITS];
    diff      = {pix_now[PIX_W-1], pix_now} - {pix_before_r[PIX_W-1], pix_before_r};
    v_tick    = {diff_r[DIFF_W-1], diff_r} + {{(V_W-OFF_W){1'b0}}, po_cur};
    v_act     = {{2{pix_prod[PIX_W-1]}}, pix_prod};
    v_mod     = (state_r == S_A_ACC) ? v_act : v_tick;
  end

  assign mod_start  = (state_r == S_T_OFF) || (state_r == S_A_ACC);
  assign last_layer = (idx_r == LIDX_W'(LAYER_COUNT - 1));
  assign out_load   = (state_r == S_FIN) && (!out_valid_r || out_beat.ready);

  // sequencer and layer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      act_r       <= 1'b0;
      cam_r       <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        acc_r[i] <= '0;
        po_r[i]  <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_FIN;
            case (psl_mode_t'(in_beat.mode))
              MODE_TICK: begin
                if (delta_in != '0) begin
                  cam_r   <= in_beat.camera_pos;
                  delta_r <= delta_in;
                  idx_r   <= '0;
                  act_r   <= 1'b0;
                  state_r <= S_T_MUL;
                end
              end
              MODE_ACT: begin
                if (sel_ok && cfg.tiles[in_beat.layer_sel] != '0) begin
                  idx_r   <= sel_idx;
                  act_r   <= 1'b1;
                  state_r <= S_A_MUL;
                end
              end
              MODE_CLR: begin
                if (sel_ok) begin
                  acc_r[sel_idx]    <= '0;
                  po_r[sel_idx]     <= '0;
                  active_r[sel_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_T_MUL: begin
          if (active_r[idx_r]) begin
            prod_r  <= mul_full[ACC_W-1:0];
            state_r <= S_T_ACC;
          end else if (last_layer) begin
            state_r <= S_FIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_T_ACC: begin
          pix_before_r  <= pix_now;
          acc_r[idx_r]  <= acc_sum;
          state_r       <= S_T_DIF;
        end
        S_T_DIF: begin
          diff_r <= diff;
          if (tiles_cur != '0 && diff != '0) begin
            state_r <= S_T_OFF;
          end else begin
            if (tiles_cur == '0) begin
              po_r[idx_r] <= '0;
            end
            if (last_layer) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_T_MUL;
            end
          end
        end
        S_T_OFF: begin
          lo_r    <= v_mod[TILE_SHIFT-1:0];
          state_r <= S_MODW;
        end
        S_A_MUL: begin
          prod_r  <= mul_full[ACC_W-1:0];
          state_r <= S_A_ACC;
        end
        S_A_ACC: begin
          acc_r[idx_r]    <= prod_r;
          active_r[idx_r] <= 1'b1;
          lo_r            <= v_mod[TILE_SHIFT-1:0];
          state_r         <= S_MODW;
        end
        S_MODW: begin
          if (mod_rsp.done) begin
            po_r[idx_r] <= {mod_rsp.rem, lo_r};
            if (act_r || last_layer) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_T_MUL;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // result register
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_mask_r  <= mask_view;
        for (int i = 0; i < MAX_LAYERS; i++) begin
          out_po_r[i] <= po_view[i];
        end
      end else if (out_valid_r && out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // layers beyond the configured count read as zero
  for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_view
    if (g < LAYER_COUNT) begin : g_used
      assign po_view[g]   = po_r[g];
      assign mask_view[g] = active_r[g];
    end else begin : g_unused
      assign po_view[g]   = '0;
      assign mask_view[g] = 1'b0;
    end
  end

  assign out_beat.valid         = out_valid_r;
  assign out_beat.offset_layer0 = out_po_r[0];
  assign out_beat.offset_layer1 = out_po_r[1];
  assign out_beat.offset_layer2 = out_po_r[2];
  assign out_beat.offset_layer3 = out_po_r[3];
  assign out_beat.active_mask   = out_mask_r;

  // checks
  `PSL_ASSERT_SAME(a_mod_start_idle, clk, rst_n, mod_start, !mod_rsp.busy,
    "remainder unit restarted while busy")
  `PSL_ASSERT_SAME(a_modw_has_work, clk, rst_n, state_r == S_MODW,
    (mod_rsp.busy || mod_rsp.done), "waiting on an idle remainder unit")
  `PSL_ASSERT_NEXT(a_cam_stable, clk, rst_n, state_r != S_IDLE, $stable(cam_r),
    "camera position changed during a command")

endmodule

`default_nettype wire

// ===== bench/parallax_scroll_layers_unit_tb.sv =====
//----------------------------------------------------------------------------
// Parallax scroll layers: block-level testbench
// Streams command beats through the unit under random sender bursts and
// receiver stalls, predicts every result beat from a behavioral copy of the
// layer state, and compares the offsets and active mask of each result beat
// in order. Register settings change between phases while the unit is idle.
//----------------------------------------------------------------------------
module parallax_scroll_layers_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psl_pkg::*;

  localparam int FRAC          = PSL_FRACTION_BITS;
  localparam int SETTLE_CYCLES = 120;
  localparam int RUN_PHASES    = 6;
  localparam int RUN_BEATS     = 145;
  localparam int HOLD_AT       = 260;
  localparam int HOLD_CYCLES   = 600;
  localparam int SHOW_LIMIT    = 10;

  // mode code the unit must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic signed [CAM_W-1:0] CAM_MAX = {1'b0, {(CAM_W-1){1'b1}}};
  localparam logic signed [CAM_W-1:0] CAM_MIN = {1'b1, {(CAM_W-1){1'b0}}};

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [CAM_W-1:0] camera_pos;
    logic [SEL_W-1:0]        layer_sel;
  } scroll_cmd_t;

  typedef struct packed {
    logic [MAX_LAYERS-1:0][OFF_W-1:0] offset;
    logic [MASK_W-1:0]                active_mask;
  } layer_view_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_pace_t;

  logic clk;
  logic rst_n = 1'b0;

  // command side drive
  logic                    cmd_valid = 1'b0;
  logic [MODE_W-1:0]       cmd_mode  = MODE_TICK;
  logic signed [CAM_W-1:0] cmd_cam   = '0;
  logic [SEL_W-1:0]        cmd_sel   = '0;
  logic                    result_ready = 1'b0;

  // register port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  psl_in_if  in_beat ();
  psl_out_if out_beat ();

  assign in_beat.valid      = cmd_valid;
  assign in_beat.mode       = cmd_mode;
  assign in_beat.camera_pos = cmd_cam;
  assign in_beat.layer_sel  = cmd_sel;
  assign out_beat.ready     = result_ready;

  parallax_scroll_layers_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .out_beat (out_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register shadow, written only while the unit is idle
  logic [CFG_W-1:0] tiles_cfg [MAX_LAYERS] = '{default: 8'd1};
  logic [CFG_W-1:0] ratio_cfg [MAX_LAYERS] = '{default: 8'd0};

  // predicted layer state
  logic signed [CAM_W-1:0] cam_now;
  logic signed [ACC_W-1:0] scroll_acc [MAX_LAYERS];
  logic [OFF_W-1:0]        pix_off [MAX_LAYERS];
  logic [MAX_LAYERS-1:0]   layer_on;

  scroll_cmd_t cmd_backlog[$];
  layer_view_t pending_views[$];

  logic                    in_took = 1'b0;
  logic                    hold_off = 1'b0;
  logic signed [CAM_W-1:0] gen_cam = '0;
  int                      beats_in = 0;
  int                      beats_out = 0;
  int                      fault_count = 0;
  int                      burst_left = 8;
  int                      gap_left = 0;
  logic [7:0]              rx_count = '0;
  rx_pace_t                rx_style = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor-mod into 0..span-1
  function automatic longint wrap_to_span(longint v, longint span);
    longint r;
    r = v % span;
    if (r < 0) r += span;
    return r;
  endfunction

  // apply one command to the predicted state and return the resulting view
  function automatic layer_view_t advance_layers(scroll_cmd_t c);
    longint            delta;
    longint            span;
    longint            px_old;
    longint            px_new;
    logic signed [63:0] sum;
    int                sel;
    layer_view_t       v;
    sel = int'(c.layer_sel);
    case (c.mode)
      MODE_TICK: begin
        delta = longint'(c.camera_pos) - longint'(cam_now);
        if (delta != 0) begin
          cam_now = c.camera_pos;
          for (int i = 0; i < PSL_LAYER_COUNT; i++) begin
            if (layer_on[i]) begin
              span   = longint'(tiles_cfg[i]) << TILE_SHIFT;
              px_old = longint'(scroll_acc[i] >>> FRAC);
              sum    = longint'(scroll_acc[i]) + delta * longint'(ratio_cfg[i]);
              // accumulator wraps at its own width
              scroll_acc[i] = sum[ACC_W-1:0];
              px_new = longint'(scroll_acc[i] >>> FRAC);
              if (span == 0) begin
                pix_off[i] = '0;
              end else if (px_new != px_old) begin
                pix_off[i] = OFF_W'(wrap_to_span(longint'(pix_off[i]) + px_new - px_old, span));
              end
            end
          end
        end
      end
      MODE_ACT: begin
        // zero width leaves the layer untouched
        if (sel < PSL_LAYER_COUNT && tiles_cfg[sel] != '0) begin
          sum = longint'(cam_now) * longint'(ratio_cfg[sel]);
          scroll_acc[sel] = sum[ACC_W-1:0];
          pix_off[sel] = OFF_W'(wrap_to_span(longint'(scroll_acc[sel] >>> FRAC),
                                             longint'(tiles_cfg[sel]) << TILE_SHIFT));
          layer_on[sel] = 1'b1;
        end
      end
      MODE_CLR: begin
        if (sel < PSL_LAYER_COUNT) begin
          scroll_acc[sel] = '0;
          pix_off[sel]    = '0;
          layer_on[sel]   = 1'b0;
        end
      end
      default: begin
      end
    endcase
    v.active_mask = '0;
    for (int i = 0; i < MAX_LAYERS; i++) begin
      v.offset[i]      = (i < PSL_LAYER_COUNT) ? pix_off[i] : '0;
      v.active_mask[i] = (i < PSL_LAYER_COUNT) && layer_on[i];
    end
    return v;
  endfunction

  // command driver: bursts with random gaps, beats change on the falling edge
  always @(negedge clk) begin : feed_cmds
    scroll_cmd_t nxt;
    if (!rst_n) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || in_took) begin
      if (gap_left > 0) begin
        cmd_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        cmd_mode  <= nxt.mode;
        cmd_cam   <= nxt.camera_pos;
        cmd_sel   <= nxt.layer_sel;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result receiver: pacing style is redrawn each time the low six bits of rx_count reach all ones
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      result_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:     result_ready <= 1'b1;
        RX_COIN:     result_ready <= ($urandom_range(0, 1) != 0);
        RX_PERIODIC: result_ready <= (rx_count[1:0] != 2'd0);
        default:     result_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
    rx_count <= rx_count + 8'd1;
    if (rx_count[5:0] == 6'd63) rx_style <= rx_pace_t'($urandom_range(0, 3));
  end

  // one long receiver stall so the unit backs up into its command input
  initial begin : long_hold
    wait (beats_in >= HOLD_AT);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // beat monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin : watch_beats
    scroll_cmd_t cmd;
    layer_view_t got;
    layer_view_t want;
    logic        bad;
    if (!rst_n) begin
      in_took <= 1'b0;
      cam_now  = '0;
      layer_on = '0;
      for (int i = 0; i < MAX_LAYERS; i++) begin
        scroll_acc[i] = '0;
        pix_off[i]    = '0;
      end
    end else begin
      in_took <= in_beat.valid && in_beat.ready;
      if (in_beat.valid && in_beat.ready) begin
        cmd.mode       = in_beat.mode;
        cmd.camera_pos = in_beat.camera_pos;
        cmd.layer_sel  = in_beat.layer_sel;
        pending_views.push_back(advance_layers(cmd));
        beats_in++;
      end
      if (out_beat.valid && out_beat.ready) begin
        got.offset[0]   = out_beat.offset_layer0;
        got.offset[1]   = out_beat.offset_layer1;
        got.offset[2]   = out_beat.offset_layer2;
        got.offset[3]   = out_beat.offset_layer3;
        got.active_mask = out_beat.active_mask;
        if (pending_views.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT)
            $display("result beat %0d with nothing pending: offsets %0d %0d %0d %0d mask %b",
                     beats_out, got.offset[0], got.offset[1], got.offset[2], got.offset[3],
                     got.active_mask);
        end else begin
          want = pending_views.pop_front();
          bad  = (got.active_mask != want.active_mask);
          for (int i = 0; i < MAX_LAYERS; i++) bad |= (got.offset[i] != want.offset[i]);
          if (bad) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT)
              $display("result beat %0d: expected %0d %0d %0d %0d mask %b, got %0d %0d %0d %0d mask %b",
                       beats_out, want.offset[0], want.offset[1], want.offset[2], want.offset[3],
                       want.active_mask, got.offset[0], got.offset[1], got.offset[2],
                       got.offset[3], got.active_mask);
          end
        end
        beats_out++;
      end
    end
  end

  task automatic queue_cmd(input logic [MODE_W-1:0] m, input logic signed [CAM_W-1:0] cam,
                           input logic [SEL_W-1:0] sel);
    scroll_cmd_t c;
    c.mode       = m;
    c.camera_pos = cam;
    c.layer_sel  = sel;
    cmd_backlog.push_back(c);
    if (m == MODE_TICK) gen_cam = cam;
  endtask

  // one register write: setup then access, done when pready is seen
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < REG_RATIO0) tiles_cfg[idx] = val;
    else ratio_cfg[idx - REG_RATIO0] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_layers(input psl_cfg_t s);
    for (int i = 0; i < MAX_LAYERS; i++) begin
      write_reg(REG_TILES0 + REG_IDX_W'(i), s.tiles[i]);
      write_reg(REG_RATIO0 + REG_IDX_W'(i), s.ratio[i]);
    end
  endtask

  // wait until every command is in and every result is out, then let the
  // unit finish any internal work
  task automatic drain_results();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || pending_views.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly camera motion over active layers; no-op beats are not counted
  task automatic queue_random_run(input int target);
    int                      counted;
    int                      pick;
    logic signed [CAM_W-1:0] cam;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        case ($urandom_range(0, 9))
          0:       cam = gen_cam;
          1:       cam = CAM_W'($urandom);
          2:       cam = ($urandom_range(0, 1) != 0) ? CAM_MAX : CAM_MIN;
          default: cam = CAM_W'(int'(gen_cam) + int'($urandom_range(0, 96)) - 48);
        endcase
        if (cam != gen_cam) counted++;
        queue_cmd(MODE_TICK, cam, SEL_W'($urandom));
      end else if (pick < 80) begin
        queue_cmd(MODE_ACT, CAM_W'($urandom), SEL_W'($urandom));
        counted++;
      end else if (pick < 93) begin
        queue_cmd(MODE_CLR, CAM_W'($urandom), SEL_W'($urandom));
        counted++;
      end else begin
        queue_cmd(MODE_SPARE, CAM_W'($urandom), SEL_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    psl_cfg_t setting;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default registers: static layers, idle camera, ignored mode
    @(posedge clk);
    queue_cmd(MODE_TICK, 16'sd100, 2'd0);
    queue_cmd(MODE_ACT, '0, 2'd0);
    queue_cmd(MODE_TICK, 16'sd100, 2'd1);
    queue_cmd(MODE_SPARE, -16'sd1, 2'd3);
    queue_cmd(MODE_ACT, '0, 2'd3);
    queue_cmd(MODE_CLR, CAM_MAX, 2'd3);
    drain_results();

    // extreme widths and ratios; layer 2 has zero width so activate is dropped
    setting.tiles = {8'd16, 8'd0, 8'd255, 8'd1};
    setting.ratio = {8'd16, 8'd128, 8'd1, 8'd255};
    load_layers(setting);
    @(posedge clk);
    queue_cmd(MODE_TICK, CAM_MIN, 2'd0);
    for (int i = 0; i < MAX_LAYERS; i++) queue_cmd(MODE_ACT, '0, SEL_W'(i));
    queue_cmd(MODE_TICK, CAM_MAX, 2'd0);
    queue_cmd(MODE_TICK, '0, 2'd1);
    queue_cmd(MODE_TICK, 16'sd1, 2'd2);
    queue_cmd(MODE_TICK, -16'sd1, 2'd3);
    drain_results();

    // ratchet layer 0 by sweeping back with ratio 0 and forward with 255
    // until its accumulator wraps; layer 3 sees a zero width tick first
    for (int k = 0; k < 4; k++) begin
      setting.tiles = {((k == 0) ? 8'd0 : 8'd16), 8'd0, 8'd255, 8'd1};
      setting.ratio = {8'd255, 8'd128, 8'd1, ((k % 2 == 0) ? 8'd0 : 8'd255)};
      load_layers(setting);
      @(posedge clk);
      queue_cmd(MODE_TICK, (k % 2 == 0) ? CAM_MIN : CAM_MAX, SEL_W'(k));
      drain_results();
    end
    @(posedge clk);
    queue_cmd(MODE_CLR, '0, 2'd3);
    queue_cmd(MODE_CLR, '0, 2'd0);
    queue_cmd(MODE_SPARE, CAM_MIN, 2'd1);
    drain_results();

    // random phases: all-max, low corner, then random register sets
    for (int p = 0; p < RUN_PHASES; p++) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
        case (p)
          0: begin
            setting.tiles[i] = 8'd255;
            setting.ratio[i] = 8'd255;
          end
          1: begin
            setting.tiles[i] = 8'd1;
            setting.ratio[i] = (i == 0) ? 8'd0 : (i == 1) ? 8'd1 : (i == 2) ? 8'd17 : 8'd255;
          end
          default: begin
            setting.tiles[i] = ($urandom_range(0, 7) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 255));
            setting.ratio[i] = CFG_W'($urandom_range(0, 255));
          end
        endcase
      end
      load_layers(setting);
      @(posedge clk);
      for (int i = 0; i < MAX_LAYERS; i++) queue_cmd(MODE_ACT, '0, SEL_W'(i));
      queue_random_run(RUN_BEATS);
      drain_results();
    end

    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/psl_pkg.sv
rtl/core/psl_in_if.sv
rtl/core/psl_out_if.sv
rtl/core/psl_cfg_regs.sv
rtl/core/psl_mod_unit.sv
rtl/core/parallax_scroll_layers_unit.sv
bench/parallax_scroll_layers_unit_tb.sv
